// ===== sv/dwis_pkg.sv =====
// ----------------------------------------------------------------------------
// dwis_pkg
// Shared types, constants and helpers of the dual-wheel speed/steer block.
// ----------------------------------------------------------------------------
package dwis_pkg;

  localparam int TABLE_DEPTH_DEF = 128;

  localparam int POS_W    = 10;
  localparam int SPEED_W  = 16;
  localparam int IDX_W    = 7;
  localparam int GAIN_W   = 8;
  localparam int TICK_W   = 13;
  localparam int SEGT_W   = 8;
  localparam int DRIVE_W  = 14;
  localparam int OUT_W    = 16;
  localparam int STEER_W  = 12;
  localparam int ENTRY_W  = 2 * SPEED_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // steering bands and offsets
  localparam logic [10:0] BAND_1 = 11'd95;
  localparam logic [10:0] BAND_2 = 11'd190;
  localparam logic [10:0] BAND_3 = 11'd286;
  localparam logic [STEER_W-1:0] STEER_1 = 12'd500;
  localparam logic [STEER_W-1:0] STEER_2 = 12'd1000;
  localparam logic [STEER_W-1:0] STEER_3 = 12'd1500;

  // drive clamp limits and forced speeds
  localparam logic [DRIVE_W-1:0] DRIVE_MIN = 14'd2;
  localparam logic [DRIVE_W-1:0] DRIVE_MAX = 14'd14998;
  localparam logic [SPEED_W-1:0] HELD_LOW  = 16'd0;
  localparam logic [SPEED_W-1:0] HELD_HIGH = 16'd250;

  // configuration reset values
  localparam logic [GAIN_W-1:0] GAIN_RST      = 8'd8;
  localparam logic [TICK_W-1:0] RUN_TICKS_RST = 13'd5000;
  localparam logic [SEGT_W-1:0] SEG_TICKS_RST = 8'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_LEFT     = 2'd0,
    CFG_GAIN_RIGHT    = 2'd1,
    CFG_RUN_TICKS     = 2'd2,
    CFG_SEGMENT_TICKS = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                      cmd;
    logic signed [POS_W-1:0]   line_position;
    logic                      left_speed_new;
    logic [SPEED_W-1:0]        left_speed;
    logic                      right_speed_new;
    logic [SPEED_W-1:0]        right_speed;
    logic [IDX_W-1:0]          entry_index;
    logic [SPEED_W-1:0]        entry_left;
    logic [SPEED_W-1:0]        entry_right;
  } in_item_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic [SPEED_W-1:0] held;
  } wheel_res_t;

  // Map a line position to a steering offset, mirrored for negative positions.
  function automatic logic signed [STEER_W-1:0] steer_for(
      input logic signed [POS_W-1:0] pos);
    logic [10:0]        mag_pos;
    logic [STEER_W-1:0] mag;
    mag_pos = pos[POS_W-1] ? (11'd0 - {1'b1, pos}) : {1'b0, pos};
    if (mag_pos == 11'd0 || mag_pos > BAND_3) begin
      mag = '0;
    end else if (mag_pos <= BAND_1) begin
      mag = STEER_1;
    end else if (mag_pos <= BAND_2) begin
      mag = STEER_2;
    end else begin
      mag = STEER_3;
    end
    return pos[POS_W-1] ? $signed(12'd0 - mag) : $signed(mag);
  endfunction

endpackage

// ===== sv/dwis_ram.sv =====
// ----------------------------------------------------------------------------
// dwis_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dwis_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/dwis_wheel.sv =====
// ----------------------------------------------------------------------------
// dwis_wheel
// Integral drive update of one wheel with clamp and held-speed override.
// ----------------------------------------------------------------------------
module dwis_wheel (
  input  logic [dwis_pkg::DRIVE_W-1:0] drive_i,
  input  logic [dwis_pkg::GAIN_W-1:0]  gain_i,
  input  logic [dwis_pkg::SPEED_W-1:0] target_i,
  input  logic [dwis_pkg::SPEED_W-1:0] held_i,
  output dwis_pkg::wheel_res_t         res_o
);

  logic signed [16:0] err;
  logic signed [25:0] prod;
  logic signed [26:0] sum;

  assign err  = $signed({1'b0, target_i}) - $signed({1'b0, held_i});
  assign prod = $signed({1'b0, gain_i}) * err;
  assign sum  = $signed({prod[25], prod}) + $signed({13'd0, drive_i});

  // clamp low forces the speed to zero, clamp high to the high mark
  always_comb begin
    if (sum < 27'sd2) begin
      res_o.drive = dwis_pkg::DRIVE_MIN;
      res_o.held  = dwis_pkg::HELD_LOW;
    end else if (sum > $signed({13'd0, dwis_pkg::DRIVE_MAX})) begin
      res_o.drive = dwis_pkg::DRIVE_MAX;
      res_o.held  = dwis_pkg::HELD_HIGH;
    end else begin
      res_o.drive = sum[dwis_pkg::DRIVE_W-1:0];
      res_o.held  = held_i;
    end
  end

endmodule

// ===== sv/dual_wheel_integral_speed_steer.sv =====
// ----------------------------------------------------------------------------
// dual_wheel_integral_speed_steer
// An accepted tick beat passes through the input register, then the result register.
// Throughput: one beat per cycle; table-load beats give no result, and a
// stalled result beat holds the input register and drops in_ready_o.
// Reset clears counters, drives, targets and held speeds, restores the config
// registers to their defaults and leaves the setpoint table as it is.
// ----------------------------------------------------------------------------
module dual_wheel_integral_speed_steer #(
  parameter int TableDepth = dwis_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [dwis_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [dwis_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // input channel
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  cmd_i,
  input  logic signed [dwis_pkg::POS_W-1:0]     line_position_i,
  input  logic                                  left_speed_new_i,
  input  logic [dwis_pkg::SPEED_W-1:0]          left_speed_i,
  input  logic                                  right_speed_new_i,
  input  logic [dwis_pkg::SPEED_W-1:0]          right_speed_i,
  input  logic [dwis_pkg::IDX_W-1:0]            entry_index_i,
  input  logic [dwis_pkg::SPEED_W-1:0]          entry_left_i,
  input  logic [dwis_pkg::SPEED_W-1:0]          entry_right_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [dwis_pkg::OUT_W-1:0]     drive_left_out_o,
  output logic signed [dwis_pkg::OUT_W-1:0]     drive_right_out_o,
  output logic                                  running_o,
  output logic [dwis_pkg::TICK_W-1:0]           log_index_o,
  output logic                                  log_valid_o,
  output logic [dwis_pkg::SPEED_W-1:0]          log_speed_o
);

  localparam int AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam logic [AddrW-1:0] IdxLast = AddrW'(TableDepth - 1);

  // --------------------------------------------------------------------------
  // Configuration registers: always ready; the user writes them while the block is idle, unenforced by the block.
  // --------------------------------------------------------------------------
  logic [dwis_pkg::GAIN_W-1:0] gain_left_q, gain_right_q;
  logic [dwis_pkg::TICK_W-1:0] run_ticks_q;
  logic [dwis_pkg::SEGT_W-1:0] seg_ticks_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_left_q  <= dwis_pkg::GAIN_RST;
      gain_right_q <= dwis_pkg::GAIN_RST;
      run_ticks_q  <= dwis_pkg::RUN_TICKS_RST;
      seg_ticks_q  <= dwis_pkg::SEG_TICKS_RST;
    end else if (cfg_valid_i) begin
      unique case (dwis_pkg::cfg_idx_e'(cfg_index_i))
        dwis_pkg::CFG_GAIN_LEFT:     gain_left_q  <= cfg_data_i[dwis_pkg::GAIN_W-1:0];
        dwis_pkg::CFG_GAIN_RIGHT:    gain_right_q <= cfg_data_i[dwis_pkg::GAIN_W-1:0];
        dwis_pkg::CFG_RUN_TICKS:     run_ticks_q  <= cfg_data_i[dwis_pkg::TICK_W-1:0];
        dwis_pkg::CFG_SEGMENT_TICKS: seg_ticks_q  <= cfg_data_i[dwis_pkg::SEGT_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register. A held beat is processed when it is a table load, or when
  // the result register is free or drains in the same cycle.
  // --------------------------------------------------------------------------
  dwis_pkg::in_item_t s1_q;
  logic               s1_valid_q;
  logic               s1_fire;
  logic               s1_tick;
  logic               out_valid_q;

  assign s1_fire    = s1_valid_q &&
                      (s1_q.cmd == dwis_pkg::CMD_LOAD || !out_valid_q || out_ready_i);
  assign s1_tick    = s1_fire && (s1_q.cmd == dwis_pkg::CMD_TICK);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q.cmd             <= dwis_pkg::cmd_e'(cmd_i);
      s1_q.line_position   <= line_position_i;
      s1_q.left_speed_new  <= left_speed_new_i;
      s1_q.left_speed      <= left_speed_i;
      s1_q.right_speed_new <= right_speed_new_i;
      s1_q.right_speed     <= right_speed_i;
      s1_q.entry_index     <= entry_index_i;
      s1_q.entry_left      <= entry_left_i;
      s1_q.entry_right     <= entry_right_i;
    end
  end

  // --------------------------------------------------------------------------
  // Controller state
  // --------------------------------------------------------------------------
  logic [dwis_pkg::TICK_W-1:0]  tick_q, tick_d;
  logic [dwis_pkg::SEGT_W-1:0]  seg_cnt_q, seg_cnt_d;
  logic [AddrW-1:0]             seg_idx_q, seg_idx_d;
  logic [dwis_pkg::DRIVE_W-1:0] drive_left_q, drive_right_q;
  logic [dwis_pkg::SPEED_W-1:0] target_left_q, target_right_q;
  logic [dwis_pkg::SPEED_W-1:0] held_left_q, held_right_q;

  // --------------------------------------------------------------------------
  // Setpoint table. The read port always fetches the entry for the segment
  // index that the next processed beat will see; a write to that entry in the
  // same cycle is forwarded.
  // --------------------------------------------------------------------------
  logic [31:0]                  wr_idx_ext;
  logic                         tbl_we;
  logic [AddrW-1:0]             tbl_waddr;
  logic [dwis_pkg::ENTRY_W-1:0] tbl_wdata, tbl_rdata, entry;
  logic                         fwd_valid_q;
  logic [dwis_pkg::ENTRY_W-1:0] fwd_data_q;

  assign wr_idx_ext = 32'(s1_q.entry_index);
  assign tbl_we     = s1_fire && (s1_q.cmd == dwis_pkg::CMD_LOAD) &&
                      (wr_idx_ext < 32'(TableDepth));
  assign tbl_waddr  = wr_idx_ext[AddrW-1:0];
  assign tbl_wdata  = {s1_q.entry_right, s1_q.entry_left};

  dwis_ram #(
    .Width (dwis_pkg::ENTRY_W),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (seg_idx_d),
    .rdata_o (tbl_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= tbl_we && (tbl_waddr == seg_idx_d);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= tbl_wdata;
  end

  assign entry = fwd_valid_q ? fwd_data_q : tbl_rdata;

  // --------------------------------------------------------------------------
  // Tick datapath: fold in fresh speeds, load targets at a segment boundary,
  // integrate each wheel, then steer the outputs.
  // --------------------------------------------------------------------------
  logic [dwis_pkg::SPEED_W-1:0]        held_left_pre, held_right_pre;
  logic [dwis_pkg::SPEED_W-1:0]        target_left_d, target_right_d;
  logic signed [dwis_pkg::STEER_W-1:0] steer;
  logic                                running;
  logic [8:0]                          cnt_inc;
  dwis_pkg::wheel_res_t                res_left, res_right;

  assign held_left_pre  = s1_q.left_speed_new  ? s1_q.left_speed  : held_left_q;
  assign held_right_pre = s1_q.right_speed_new ? s1_q.right_speed : held_right_q;

  assign target_left_d  = (seg_cnt_q == '0) ? entry[dwis_pkg::SPEED_W-1:0] : target_left_q;
  assign target_right_d = (seg_cnt_q == '0) ? entry[dwis_pkg::ENTRY_W-1:dwis_pkg::SPEED_W]
                                            : target_right_q;

  // steering only on even ticks
  assign steer   = tick_q[0] ? '0 : dwis_pkg::steer_for(s1_q.line_position);
  assign running = tick_q < run_ticks_q;
  assign cnt_inc = {1'b0, seg_cnt_q} + 9'd1;

  dwis_wheel u_wheel_left (
    .drive_i  (drive_left_q),
    .gain_i   (gain_left_q),
    .target_i (target_left_d),
    .held_i   (held_left_pre),
    .res_o    (res_left)
  );

  dwis_wheel u_wheel_right (
    .drive_i  (drive_right_q),
    .gain_i   (gain_right_q),
    .target_i (target_right_d),
    .held_i   (held_right_pre),
    .res_o    (res_right)
  );

  // Advance the counters only on a running tick; a segment length of zero
  // acts as one.
  always_comb begin
    tick_d    = tick_q;
    seg_cnt_d = seg_cnt_q;
    seg_idx_d = seg_idx_q;
    if (s1_tick && running) begin
      tick_d = tick_q + 1'b1;
      if (cnt_inc >= {1'b0, seg_ticks_q}) begin
        seg_cnt_d = '0;
        if (seg_idx_q < IdxLast) begin
          seg_idx_d = seg_idx_q + 1'b1;
        end
      end else begin
        seg_cnt_d = cnt_inc[dwis_pkg::SEGT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q         <= '0;
      seg_cnt_q      <= '0;
      seg_idx_q      <= '0;
      drive_left_q   <= '0;
      drive_right_q  <= '0;
      target_left_q  <= '0;
      target_right_q <= '0;
      held_left_q    <= '0;
      held_right_q   <= '0;
    end else begin
      tick_q    <= tick_d;
      seg_cnt_q <= seg_cnt_d;
      seg_idx_q <= seg_idx_d;
      if (s1_tick) begin
        drive_left_q   <= res_left.drive;
        drive_right_q  <= res_right.drive;
        target_left_q  <= target_left_d;
        target_right_q <= target_right_d;
        held_left_q    <= res_left.held;
        held_right_q   <= res_right.held;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register: load on a processed tick, drop when the beat is taken.
  // --------------------------------------------------------------------------
  logic signed [dwis_pkg::OUT_W-1:0] drv_left_out_q, drv_right_out_q;
  logic                              running_q;
  logic [dwis_pkg::TICK_W-1:0]       log_index_q;
  logic [dwis_pkg::SPEED_W-1:0]      log_speed_q;
  logic signed [dwis_pkg::OUT_W-1:0] steer_ext;

  assign steer_ext = {{(dwis_pkg::OUT_W - dwis_pkg::STEER_W){steer[dwis_pkg::STEER_W-1]}},
                      steer};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_tick) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_tick) begin
      running_q <= running;
      if (running) begin
        drv_left_out_q  <= $signed({2'b00, res_left.drive}) - steer_ext;
        drv_right_out_q <= $signed({2'b00, res_right.drive}) + steer_ext;
        log_index_q     <= tick_d;
        log_speed_q     <= res_left.held;
      end else begin
        drv_left_out_q  <= '0;
        drv_right_out_q <= '0;
        log_index_q     <= '0;
        log_speed_q     <= '0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign drive_left_out_o  = drv_left_out_q;
  assign drive_right_out_o = drv_right_out_q;
  assign running_o         = running_q;
  assign log_valid_o       = running_q;
  assign log_index_o       = log_index_q;
  assign log_speed_o       = log_speed_q;

endmodule

// ===== sv/dwis_checker.sv =====
// ----------------------------------------------------------------------------
// dwis_checker
// Port-level checks of the speed/steer block, bound to its top level.
// ----------------------------------------------------------------------------
module dwis_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [dwis_pkg::OUT_W-1:0] drive_left_out_o,
  input logic signed [dwis_pkg::OUT_W-1:0] drive_right_out_o,
  input logic                              running_o,
  input logic [dwis_pkg::TICK_W-1:0]       log_index_o,
  input logic                              log_valid_o,
  input logic [dwis_pkg::SPEED_W-1:0]      log_speed_o
);

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its drives
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(drive_left_out_o) && $stable(drive_right_out_o))
    else $error("result drives changed while stalled");

  // the log record flag follows the running flag
  a_log_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (log_valid_o == running_o))
    else $error("log_valid differs from running");

  // a stopped tick carries zero drive and an empty record
  a_stopped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !running_o |-> drive_left_out_o == '0 && drive_right_out_o == '0 &&
                                  log_index_o == '0 && log_speed_o == '0)
    else $error("stopped tick carries non-zero fields");

  // a running tick has advanced the tick count past zero
  a_running_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && running_o |-> log_index_o != '0)
    else $error("running tick with zero log index");

endmodule

bind dual_wheel_integral_speed_steer dwis_checker u_dwis_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual-wheel integral speed/steer controller.
// A behavioural copy of the controller predicts every result beat; a checker
// compares each accepted beat field by field against the oldest prediction.
// Stimulus: table fill, directed steering bands, clamps, run limit and zero
// segment length, a long receiver hold-off that backs the block up, then
// randomised phases with fresh register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import dwis_pkg::*;

  localparam int          DEPTH       = TABLE_DEPTH_DEF;
  localparam int          SETTLE      = 8;       // cycles after the last result
  localparam int unsigned LIMIT       = 600000;  // watchdog, in clock cycles
  localparam int          PHASES      = 12;
  localparam int          PHASE_BEATS = 137;
  localparam int          MAX_GAP     = 19;
  localparam int          HOLD_CYCLES = 300;

  // One result beat as seen on the output channel
  typedef struct packed {
    logic signed [OUT_W-1:0] drive_left;
    logic signed [OUT_W-1:0] drive_right;
    logic                    running;
    logic [TICK_W-1:0]       log_index;
    logic                    log_valid;
    logic [SPEED_W-1:0]      log_speed;
  } drive_beat_t;

  // --------------------------------------------------------------------------
  // DUT connections, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic                       clk_i             = 1'b0;
  logic                       rst_ni            = 1'b0;
  logic                       cfg_valid_i       = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i       = '0;
  logic [CFG_DATA_W-1:0]      cfg_data_i        = '0;
  logic                       in_valid_i        = 1'b0;
  logic                       in_ready_o;
  logic                       cmd_i             = 1'b0;
  logic signed [POS_W-1:0]    line_position_i   = '0;
  logic                       left_speed_new_i  = 1'b0;
  logic [SPEED_W-1:0]         left_speed_i      = '0;
  logic                       right_speed_new_i = 1'b0;
  logic [SPEED_W-1:0]         right_speed_i     = '0;
  logic [IDX_W-1:0]           entry_index_i     = '0;
  logic [SPEED_W-1:0]         entry_left_i      = '0;
  logic [SPEED_W-1:0]         entry_right_i     = '0;
  logic                       out_valid_o;
  logic                       out_ready_i       = 1'b0;
  logic signed [OUT_W-1:0]    drive_left_out_o;
  logic signed [OUT_W-1:0]    drive_right_out_o;
  logic                       running_o;
  logic [TICK_W-1:0]          log_index_o;
  logic                       log_valid_o;
  logic [SPEED_W-1:0]         log_speed_o;

  dual_wheel_integral_speed_steer u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .cmd_i             (cmd_i),
    .line_position_i   (line_position_i),
    .left_speed_new_i  (left_speed_new_i),
    .left_speed_i      (left_speed_i),
    .right_speed_new_i (right_speed_new_i),
    .right_speed_i     (right_speed_i),
    .entry_index_i     (entry_index_i),
    .entry_left_i      (entry_left_i),
    .entry_right_i     (entry_right_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .drive_left_out_o  (drive_left_out_o),
    .drive_right_out_o (drive_right_out_o),
    .running_o         (running_o),
    .log_index_o       (log_index_o),
    .log_valid_o       (log_valid_o),
    .log_speed_o       (log_speed_o)
  );

  // 4 ns period: 2 ns high, 2 ns low
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Controller copy: register settings and internal state
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0]  gain_l     = GAIN_RST;
  logic [GAIN_W-1:0]  gain_r     = GAIN_RST;
  logic [TICK_W-1:0]  run_limit  = RUN_TICKS_RST;
  logic [SEGT_W-1:0]  seg_len    = SEG_TICKS_RST;
  logic [TICK_W-1:0]  ticks_done = '0;
  int                 seg_count  = 0;
  int                 seg_idx    = 0;
  int                 drv_l      = 0;
  int                 drv_r      = 0;
  logic [SPEED_W-1:0] tgt_l      = '0;
  logic [SPEED_W-1:0] tgt_r      = '0;
  logic [SPEED_W-1:0] held_l     = '0;
  logic [SPEED_W-1:0] held_r     = '0;
  logic [ENTRY_W-1:0] setpoints [DEPTH];

  // Predicted result beats, oldest first
  drive_beat_t pending_drives [$];

  // Run statistics and error count
  int mismatches    = 0;
  int ticks_sent    = 0;
  int stopped_ticks = 0;
  int loads_sent    = 0;
  int reg_writes    = 0;
  int results_seen  = 0;
  int clamps_low    = 0;
  int clamps_high   = 0;
  bit last_seg_seen = 1'b0;

  // Idling control shared by both sides
  bit   no_idle   = 1'b0;
  int   sink_wait = 0;
  bit   hold_on   = 1'b0;
  event sink_pause;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Steering offset for a line position; mirrored bands for negative values
  function automatic int steer_offset(logic signed [POS_W-1:0] pos);
    int p;
    int a;
    int mag;
    p = pos;
    a = (p < 0) ? -p : p;
    if (a == 0 || a > int'(BAND_3)) begin
      mag = 0;
    end else if (a <= int'(BAND_1)) begin
      mag = int'(STEER_1);
    end else if (a <= int'(BAND_2)) begin
      mag = int'(STEER_2);
    end else begin
      mag = int'(STEER_3);
    end
    return (p < 0) ? -mag : mag;
  endfunction

  // Integrate one wheel and apply the clamp, overriding the held speed
  function automatic int drive_step(int drive, logic [GAIN_W-1:0] gain,
                                    logic [SPEED_W-1:0] tgt,
                                    inout logic [SPEED_W-1:0] held);
    longint v;
    v = longint'(drive) + longint'(gain) * (longint'(tgt) - longint'(held));
    if (v < longint'(DRIVE_MIN)) begin
      held = HELD_LOW;
      clamps_low++;
      return int'(DRIVE_MIN);
    end
    if (v > longint'(DRIVE_MAX)) begin
      held = HELD_HIGH;
      clamps_high++;
      return int'(DRIVE_MAX);
    end
    return int'(v);
  endfunction

  // Fold one accepted input beat into the controller copy
  task automatic advance_controller(input in_item_t it);
    int                 steer;
    logic [ENTRY_W-1:0] entry;
    drive_beat_t        want;
    if (it.cmd == CMD_LOAD) begin
      setpoints[it.entry_index] = {it.entry_right, it.entry_left};
      loads_sent++;
    end else begin
      ticks_sent++;
      if (it.left_speed_new) held_l = it.left_speed;
      if (it.right_speed_new) held_r = it.right_speed;
      steer = ticks_done[0] ? 0 : steer_offset(it.line_position);
      // load fresh targets on a segment boundary
      if (seg_count == 0) begin
        entry = setpoints[seg_idx];
        tgt_l = entry[SPEED_W-1:0];
        tgt_r = entry[ENTRY_W-1:SPEED_W];
      end
      drv_l = drive_step(drv_l, gain_l, tgt_l, held_l);
      drv_r = drive_step(drv_r, gain_r, tgt_r, held_r);
      if (ticks_done < run_limit) begin
        ticks_done = ticks_done + 1'b1;
        seg_count++;
        // a segment length of zero acts as one
        if (seg_count >= int'(seg_len)) begin
          seg_count = 0;
          if (seg_idx < DEPTH - 1) seg_idx++;
        end
        want.drive_left  = OUT_W'(drv_l - steer);
        want.drive_right = OUT_W'(drv_r + steer);
        want.running     = 1'b1;
        want.log_index   = ticks_done;
        want.log_valid   = 1'b1;
        want.log_speed   = held_l;
      end else begin
        // past the run limit: motors off, nothing logged
        want = '0;
        stopped_ticks++;
      end
      if (seg_idx == DEPTH - 1) last_seg_seen = 1'b1;
      pending_drives.push_back(want);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Setpoint value: mostly modest speeds, with the extremes mixed in
  function automatic logic [SPEED_W-1:0] pick_speed();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return SPEED_W'($urandom);
      default: return SPEED_W'($urandom_range(0, 4000));
    endcase
  endfunction

  // Measured speed: usually close to the target so the drive stays inside
  // its limits, sometimes wild to reach the clamps
  function automatic logic [SPEED_W-1:0] measured_speed(logic [SPEED_W-1:0] tgt);
    int v;
    case ($urandom_range(0, 9))
      6, 7: return SPEED_W'($urandom);
      8:    return '0;
      9:    return '1;
      default: begin
        v = int'(tgt) + int'($urandom_range(0, 128)) - 64;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return SPEED_W'(v);
      end
    endcase
  endfunction

  // Build one input beat with every field randomised
  function automatic in_item_t random_item(bit load);
    in_item_t it;
    it.cmd             = load ? CMD_LOAD : CMD_TICK;
    it.line_position   = POS_W'($urandom);
    it.left_speed_new  = ($urandom_range(0, 9) < 7);
    it.left_speed      = measured_speed(tgt_l);
    it.right_speed_new = ($urandom_range(0, 9) < 7);
    it.right_speed     = measured_speed(tgt_r);
    // aim half the table writes at the entry about to be read
    if ($urandom_range(0, 1) == 1) begin
      it.entry_index = IDX_W'(($urandom_range(0, 1) == 1 && seg_idx < DEPTH - 1) ?
                              seg_idx + 1 : seg_idx);
    end else begin
      it.entry_index = IDX_W'($urandom);
    end
    it.entry_left  = pick_speed();
    it.entry_right = pick_speed();
    return it;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return CFG_DATA_W'(0);
      1:       return CFG_DATA_W'(255);
      default: return CFG_DATA_W'($urandom_range(1, 24));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers: change inputs on the falling edge, sample on the rising
  // --------------------------------------------------------------------------

  // Offer one input beat after a random gap and hold it until accepted
  task automatic send_beat(input in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    cmd_i             <= it.cmd;
    line_position_i   <= it.line_position;
    left_speed_new_i  <= it.left_speed_new;
    left_speed_i      <= it.left_speed;
    right_speed_new_i <= it.right_speed_new;
    right_speed_i     <= it.right_speed;
    entry_index_i     <= it.entry_index;
    entry_left_i      <= it.entry_left;
    entry_right_i     <= it.entry_right;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    advance_controller(it);
  endtask

  // Write one register and mirror it in the controller copy
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_GAIN_LEFT:     gain_l    = val[GAIN_W-1:0];
      CFG_GAIN_RIGHT:    gain_r    = val[GAIN_W-1:0];
      CFG_RUN_TICKS:     run_limit = val[TICK_W-1:0];
      CFG_SEGMENT_TICKS: seg_len   = val[SEGT_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drop valid, wait for every predicted beat, then let table writes settle
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, long hold-off and the checker
  // --------------------------------------------------------------------------
  always @(negedge clk_i) out_ready_i <= rst_ni && !hold_on && (sink_wait == 0);

  // Count the long hold-off in its own process
  initial begin : sink_hold
    forever begin
      @(sink_pause);
      hold_on = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_on = 1'b0;
    end
  end

  always @(posedge clk_i) begin : drive_check
    drive_beat_t got;
    drive_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.drive_left  = drive_left_out_o;
      got.drive_right = drive_right_out_o;
      got.running     = running_o;
      got.log_index   = log_index_o;
      got.log_valid   = log_valid_o;
      got.log_speed   = log_speed_o;
      results_seen++;
      if (pending_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] unexpected result beat: drv %0d/%0d run %0b idx %0d log %0b spd %0d",
                   $time, $signed(got.drive_left), $signed(got.drive_right), got.running,
                   got.log_index, got.log_valid, got.log_speed);
        end
      end else begin
        want = pending_drives.pop_front();
        if (got.drive_left !== want.drive_left || got.drive_right !== want.drive_right ||
            got.running !== want.running || got.log_index !== want.log_index ||
            got.log_valid !== want.log_valid || got.log_speed !== want.log_speed) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] beat %0d mismatch", $time, results_seen);
            $display("  exp: drv %0d/%0d run %0b idx %0d log %0b spd %0d",
                     $signed(want.drive_left), $signed(want.drive_right), want.running,
                     want.log_index, want.log_valid, want.log_speed);
            $display("  got: drv %0d/%0d run %0b idx %0d log %0b spd %0d",
                     $signed(got.drive_left), $signed(got.drive_right), got.running,
                     got.log_index, got.log_valid, got.log_speed);
          end
        end
      end
      sink_wait <= no_idle ? 0 : $urandom_range(0, MAX_GAP);
    end else if (sink_wait > 0) begin
      sink_wait <= sink_wait - 1;
    end
  end

  // Watchdog: fail the run if it has not finished within the cycle limit
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Watchdog expired after %0d cycles, %0d beats still pending",
             cycle_count, pending_drives.size());
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Write every table entry so no tick ever reads an empty slot
  task automatic fill_setpoint_table();
    in_item_t it;
    for (int k = 0; k < DEPTH; k++) begin
      it = random_item(1'b1);
      it.entry_index = IDX_W'(k);
      send_beat(it);
    end
  endtask

  // Band edges on both sides of centre, plus the position extremes
  task automatic test_steer_bands();
    int       positions [17] = '{0, 1, 95, 96, 190, 191, 286, 287, 511,
                                 -1, -95, -96, -190, -191, -286, -287, -512};
    in_item_t it;
    foreach (positions[k]) begin
      it = random_item(1'b0);
      it.line_position = POS_W'(positions[k]);
      send_beat(it);
    end
  endtask

  // Drive both wheels into opposite clamps, then swap them over.
  // Relies on a segment length of one, so every tick reloads its targets.
  task automatic test_clamp_limits();
    in_item_t it;
    for (int swap = 0; swap < 2; swap++) begin
      it = random_item(1'b1);
      it.entry_index = IDX_W'(seg_idx);
      it.entry_left  = swap ? '1 : '0;
      it.entry_right = swap ? '0 : '1;
      send_beat(it);
      it = random_item(1'b0);
      it.left_speed_new  = 1'b1;
      it.left_speed      = swap ? '0 : '1;
      it.right_speed_new = 1'b1;
      it.right_speed     = swap ? '1 : '0;
      send_beat(it);
    end
  endtask

  // Run into the tick limit, then stop outright with a limit of zero
  task automatic test_run_limit();
    drain();
    write_reg(CFG_RUN_TICKS, CFG_DATA_W'(ticks_done + 2));
    repeat (4) send_beat(random_item(1'b0));
    drain();
    write_reg(CFG_RUN_TICKS, '0);
    send_beat(random_item(1'b0));
    drain();
    write_reg(CFG_RUN_TICKS, '1);
  endtask

  // A segment length of zero must advance the segment on every tick
  task automatic test_zero_segment_length();
    drain();
    write_reg(CFG_SEGMENT_TICKS, '0);
    repeat (2) send_beat(random_item(1'b0));
  endtask

  // Random phases, each with its own register settings
  task automatic test_random_phases();
    logic [CFG_DATA_W-1:0] seg_val;
    logic [CFG_DATA_W-1:0] run_val;
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_reg(CFG_GAIN_LEFT, (p == 1) ? CFG_DATA_W'(0) :
                               (p == 2) ? CFG_DATA_W'(255) : pick_gain());
      write_reg(CFG_GAIN_RIGHT, (p == 1) ? CFG_DATA_W'(255) :
                                (p == 2) ? CFG_DATA_W'(0) : pick_gain());
      // short segments at the end walk the index onto the last entry
      if (p >= PHASES - 2) begin
        seg_val = CFG_DATA_W'(1);
      end else if (p == 3) begin
        seg_val = CFG_DATA_W'(255);
      end else begin
        seg_val = CFG_DATA_W'($urandom_range(2, 30));
      end
      write_reg(CFG_SEGMENT_TICKS, seg_val);
      // one phase stops part-way through
      run_val = (p == 5) ? CFG_DATA_W'(ticks_done + $urandom_range(20, 80)) : '1;
      write_reg(CFG_RUN_TICKS, run_val);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (PHASE_BEATS) send_beat(random_item($urandom_range(0, 3) == 0));
      no_idle = 1'b0;
    end
  endtask

  // Hold the receiver off while beats keep coming, so the input stalls
  task automatic test_backpressure();
    drain();
    no_idle = 1'b1;
    -> sink_pause;
    repeat (100) send_beat(random_item($urandom_range(0, 3) == 0));
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run_tests
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_reg(CFG_GAIN_LEFT, CFG_DATA_W'(GAIN_RST));
    write_reg(CFG_GAIN_RIGHT, CFG_DATA_W'(GAIN_RST));
    write_reg(CFG_RUN_TICKS, '1);
    write_reg(CFG_SEGMENT_TICKS, CFG_DATA_W'(1));

    fill_setpoint_table();
    test_steer_bands();
    test_clamp_limits();
    test_run_limit();
    test_zero_segment_length();
    test_backpressure();
    test_random_phases();
    drain();

    $display("Covered %0d control ticks (%0d past the run limit), %0d table writes, %0d reg writes",
             ticks_sent, stopped_ticks, loads_sent, reg_writes);
    $display("Checked %0d result beats; clamps %0d low / %0d high; last segment %0s; %0d errors",
             results_seen, clamps_low, clamps_high, last_seg_seen ? "reached" : "not reached",
             mismatches + pending_drives.size());
    if (mismatches == 0 && pending_drives.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
